FILE: src/failed_login_address_table_macros.svh
// Assertion macros shared by the failed-login address table modules.
`ifndef FAILED_LOGIN_ADDRESS_TABLE_MACROS_SVH
`define FAILED_LOGIN_ADDRESS_TABLE_MACROS_SVH

// Same-cycle implication, checked at the rising clock edge outside reset.
`define FLAT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at the rising clock edge outside reset.
`define FLAT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/flat_pkg.sv
// Package of the failed-login address table: sizes, entry layout and control types.
package flat_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int ADDR_W      = 32;
   localparam int TIME_W      = 32;
   localparam int COUNT_W     = 8;
   localparam int ENTRY_W     = ADDR_W + TIME_W + COUNT_W;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      ACT_RECORD = 2'd0,
      ACT_CLEAR  = 2'd1,
      ACT_QUERY  = 2'd2
   } flat_action_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [TIME_W-1:0]  last_time;
      logic [ADDR_W-1:0]  addr;
   } flat_entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // latch the incoming word and restart the scan
      logic issue;   // read the table entry at the scan index
      logic commit;  // apply the update and load the result register
   } flat_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_last;  // the scan index points at the last entry
      logic out_busy;   // the result register holds a word that is not taken
   } flat_status_type;

endpackage

FILE: src/failed_login_address_table.sv
// Top level of the failed-login address table.
//
// The block keeps a table of TABLE_DEPTH entries (16 here), each holding an IPv4
// address, a saturating 8-bit fail count and the time of the last failure; a
// cleared valid bit marks a free entry. A request word carries an action in
// req_tuser and the address and current time in req_tdata. Record failure finds
// the address, or else the lowest free entry, or else evicts the entry with the
// oldest failure time (lowest index on ties, count restarting), stores address
// and time, bumps the count and reports it. Query reports the count of an
// address, and clear frees its entry. Every request produces exactly one
// response word: the count in rsp_tdata and a found flag in rsp_tuser. Each
// request is handled by a scan, which reads one entry per cycle through the
// single read port of the entry RAM, then a drain state for the last compare
// and an update state for the write-back, which waits while the result
// register still holds a word that is not taken. One request is in work
// at a time; the next word is accepted as soon as the previous update is
// done, even while its response still waits in the output register. After
// reset the table is empty at once, since per-entry valid bits are cleared
// by reset and no clearing pass is needed.
module failed_login_address_table
   import flat_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] address, [63:32] now
   input  logic [1:0]  req_tuser,   // [1:0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] fail_count
   output logic [0:0]  rsp_tuser    // [0] found
);

   // The controller sequences accept, scan, drain and update; the datapath
   // holds the table, the scan results and the response register.
   flat_cmd_type    cmd;
   flat_status_type status;

   flat_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   flat_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: src/flat_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module flat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/flat_ctrl.sv
// Controller state machine of the failed-login address table.
module flat_ctrl
   import flat_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  flat_status_type status,
   output flat_cmd_type    cmd
);

`include "failed_login_address_table_macros.svh"

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_UPDATE = 4'b1000
   } flat_state_type;

   flat_state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      cmd.load   = req_tvalid && req_tready;
      cmd.issue  = (state_ff == ST_SCAN);
      cmd.commit = (state_ff == ST_UPDATE) && !status.out_busy;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.load) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_last) state_in = ST_DRAIN;
         end
         // The last entry's read data is evaluated here.
         ST_DRAIN: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (cmd.commit) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `FLAT_ASSERT_NXT(a_load_starts_scan, clock, reset, cmd.load, state_ff == ST_SCAN, "accepted word did not start a scan")
   `FLAT_ASSERT_NXT(a_commit_frees_input, clock, reset, cmd.commit, req_tready, "input not ready after an update")

endmodule

FILE: src/flat_datapath.sv
// Datapath of the failed-login address table: entry store, scan logic and result register.
module flat_datapath
   import flat_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  flat_cmd_type    cmd,
   output flat_status_type status,
   input  logic [1:0]      req_tuser,
   input  logic [63:0]     req_tdata,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [7:0]      rsp_tdata,
   output logic [0:0]      rsp_tuser
);

`include "failed_login_address_table_macros.svh"

   // Latched request.
   flat_action_type     act_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [TIME_W-1:0]   now_ff;

   // Scan and read pipeline.
   logic [IDX_W-1:0]    scan_idx_ff, scan_idx_in;
   logic                rd_pend_ff;
   logic [IDX_W-1:0]    rd_idx_ff;

   // Scan results.
   logic                hit_ff, hit_in;
   logic [IDX_W-1:0]    hit_idx_ff, hit_idx_in;
   logic [COUNT_W-1:0]  hit_count_ff, hit_count_in;
   logic                free_ff, free_in;
   logic [IDX_W-1:0]    free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]    old_idx_ff, old_idx_in;
   logic [TIME_W-1:0]   old_time_ff, old_time_in;

   // Entry occupancy; an entry that is not valid reads as all zero.
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic [ENTRY_W-1:0]  ram_rd_data;
   flat_entry_type      ent;
   logic                ent_valid;
   flat_entry_type      wr_ent;

   logic [COUNT_W-1:0]  base_count;
   logic [COUNT_W-1:0]  next_count;
   logic [IDX_W-1:0]    slot;
   logic                do_write;
   logic                do_clear;
   logic                upd_found;
   logic [COUNT_W-1:0]  upd_count;

   assign ent_valid = valid_ff[rd_idx_ff];
   assign ent       = ent_valid ? flat_entry_type'(ram_rd_data) : '0;

   always_comb begin
      status.scan_last = (scan_idx_ff == IDX_W'(TABLE_DEPTH - 1));
      status.out_busy  = rsp_valid_ff && !rsp_tready;
   end

   always_comb begin
      if (cmd.load) begin
         scan_idx_in = '0;
      end else if (cmd.issue) begin
         scan_idx_in = scan_idx_ff + IDX_W'(1);
      end else begin
         scan_idx_in = scan_idx_ff;
      end
   end

   // Scan: first match, lowest free entry, oldest entry with lowest index on ties.
   always_comb begin
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_count_in = hit_count_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      old_idx_in   = old_idx_ff;
      old_time_in  = old_time_ff;
      if (cmd.load) begin
         hit_in  = 1'b0;
         free_in = 1'b0;
      end else if (rd_pend_ff) begin
         if (!hit_ff && ent_valid && (ent.addr == addr_ff)) begin
            hit_in       = 1'b1;
            hit_idx_in   = rd_idx_ff;
            hit_count_in = ent.count;
         end
         if (!free_ff && !ent_valid) begin
            free_in     = 1'b1;
            free_idx_in = rd_idx_ff;
         end
         if ((rd_idx_ff == '0) || (ent.last_time < old_time_ff)) begin
            old_idx_in  = rd_idx_ff;
            old_time_in = ent.last_time;
         end
      end
   end

   // Update decision; a new entry's count restarts from zero.
   assign base_count = hit_ff ? hit_count_ff : '0;
   assign next_count = (base_count == COUNT_MAX) ? base_count : base_count + COUNT_W'(1);

   always_comb begin
      if (hit_ff) begin
         slot = hit_idx_ff;
      end else if (free_ff) begin
         slot = free_idx_ff;
      end else begin
         slot = old_idx_ff;
      end
   end

   always_comb begin
      do_write  = 1'b0;
      do_clear  = 1'b0;
      upd_found = 1'b0;
      upd_count = '0;
      if (addr_ff != '0) begin
         unique case (act_ff)
            ACT_RECORD: begin
               do_write  = 1'b1;
               upd_found = 1'b1;
               upd_count = next_count;
            end
            ACT_CLEAR: begin
               do_clear = hit_ff;
            end
            ACT_QUERY: begin
               upd_found = hit_ff;
               upd_count = hit_ff ? hit_count_ff : '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.commit && do_write) begin
         valid_in[slot] = 1'b1;
      end
      if (cmd.commit && do_clear) begin
         valid_in[hit_idx_ff] = 1'b0;
      end
   end

   always_comb begin
      wr_ent.count     = next_count;
      wr_ent.last_time = now_ff;
      wr_ent.addr      = addr_ff;
   end

   always_comb begin
      rsp_found_in = rsp_found_ff;
      rsp_count_in = rsp_count_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = upd_found;
         rsp_count_in = upd_count;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   flat_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.commit && do_write),
      .wr_addr (slot),
      .wr_data (wr_ent),
      .rd_en   (cmd.issue),
      .rd_addr (scan_idx_ff),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff   <= cmd.issue;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff  <= flat_action_type'(req_tuser);
         addr_ff <= req_tdata[ADDR_W-1:0];
         now_ff  <= req_tdata[ADDR_W+TIME_W-1:ADDR_W];
      end
      scan_idx_ff  <= scan_idx_in;
      rd_idx_ff    <= scan_idx_ff;
      hit_idx_ff   <= hit_idx_in;
      hit_count_ff <= hit_count_in;
      free_idx_ff  <= free_idx_in;
      old_idx_ff   <= old_idx_in;
      old_time_ff  <= old_time_in;
      rsp_found_ff <= rsp_found_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_count_ff;
   assign rsp_tuser  = rsp_found_ff;

   `FLAT_ASSERT_IMP(a_commit_out_free, clock, reset, cmd.commit, !status.out_busy, "update overwrote a pending result")
   `FLAT_ASSERT_IMP(a_found_has_count, clock, reset, rsp_valid_ff && rsp_found_ff, rsp_count_ff != '0, "found result with zero count")
   `FLAT_ASSERT_NXT(a_record_found, clock, reset, cmd.commit && (act_ff == ACT_RECORD) && (addr_ff != '0), rsp_valid_ff && rsp_found_ff && (valid_ff != '0), "recorded address not reported as found")

endmodule
